// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker modules of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define ASSERT_IMPLIES(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while dis is high.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/dtse_pkg.sv =====
// ----------------------------------------------------------------------------
// dtse_pkg
// Types, widths and codes shared by the split evaluator modules.
// ----------------------------------------------------------------------------
package dtse_pkg;

  localparam int ACC_W       = 40;
  localparam int FEAT_W      = 16;
  localparam int WGT_W       = 16;
  localparam int PROD_W      = FEAT_W + WGT_W;
  localparam int SLOT_W      = 3;
  localparam int CNT_W       = 4;
  localparam int MODE_W      = 2;
  localparam int HW_SLOTS    = 8;
  localparam int WIDE_SHIFT  = 15;
  localparam int CFG_DW      = 64;
  localparam int CFG_AW      = 6;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef logic signed [WGT_W-1:0]  wgt_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_FEATURE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_THRESHOLD = 2'd0,
    MODE_OBLIQUE   = 2'd1,
    MODE_ORDINAL   = 2'd2
  } split_mode_t;

  typedef enum logic [2:0] {
    REG_SPLIT_MODE  = 3'd0,
    REG_SLOT_COUNT  = 3'd1,
    REG_THRESHOLD   = 3'd2,
    REG_BIAS        = 3'd3,
    REG_ORD_TARGET  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0] split_mode;
    logic [CNT_W-1:0]  slot_count;
    acc_t              threshold;
    acc_t              bias;
    logic [SLOT_W-1:0] ordinal_target;
  } cfg_t;

  typedef struct packed {
    logic              first;
    logic              last;
    logic              oblique;
    logic              ordinal;
    logic [SLOT_W-1:0] slot;
    feat_t             feat;
    prod_t             prod;
  } eval_t;

endpackage

// ===== hdl/dtse_ram.sv =====
// ----------------------------------------------------------------------------
// dtse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dtse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/dtse_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dtse_cfg_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module dtse_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dtse_pkg::CFG_AW-1:0]  paddr,
  input  logic [dtse_pkg::CFG_DW-1:0]  pwdata,
  output logic [dtse_pkg::CFG_DW-1:0]  prdata,
  output dtse_pkg::cfg_t               cfg
);

  dtse_pkg::cfg_t     cfg_r;
  dtse_pkg::cfg_t     cfg_nxt;
  dtse_pkg::reg_idx_t idx;
  logic               wr;

  assign idx = dtse_pkg::reg_idx_t'(paddr[dtse_pkg::CFG_AW-1:3]);
  assign wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        dtse_pkg::REG_SPLIT_MODE: begin
          cfg_nxt.split_mode = pwdata[dtse_pkg::MODE_W-1:0];
        end
        dtse_pkg::REG_SLOT_COUNT: begin
          cfg_nxt.slot_count = pwdata[dtse_pkg::CNT_W-1:0];
        end
        dtse_pkg::REG_THRESHOLD: begin
          cfg_nxt.threshold = pwdata[dtse_pkg::ACC_W-1:0];
        end
        dtse_pkg::REG_BIAS: begin
          cfg_nxt.bias = pwdata[dtse_pkg::ACC_W-1:0];
        end
        dtse_pkg::REG_ORD_TARGET: begin
          cfg_nxt.ordinal_target = pwdata[dtse_pkg::SLOT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      dtse_pkg::REG_SPLIT_MODE: begin
        prdata = dtse_pkg::CFG_DW'(cfg_r.split_mode);
      end
      dtse_pkg::REG_SLOT_COUNT: begin
        prdata = dtse_pkg::CFG_DW'(cfg_r.slot_count);
      end
      dtse_pkg::REG_THRESHOLD: begin
        prdata = {{(dtse_pkg::CFG_DW-dtse_pkg::ACC_W){cfg_r.threshold[dtse_pkg::ACC_W-1]}},
                  cfg_r.threshold};
      end
      dtse_pkg::REG_BIAS: begin
        prdata = {{(dtse_pkg::CFG_DW-dtse_pkg::ACC_W){cfg_r.bias[dtse_pkg::ACC_W-1]}},
                  cfg_r.bias};
      end
      dtse_pkg::REG_ORD_TARGET: begin
        prdata = dtse_pkg::CFG_DW'(cfg_r.ordinal_target);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.split_mode     <= '0;
      cfg_r.slot_count     <= dtse_pkg::CNT_W'(1);
      cfg_r.threshold      <= '0;
      cfg_r.bias           <= '0;
      cfg_r.ordinal_target <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/dtse_eval.sv =====
// ----------------------------------------------------------------------------
// dtse_eval
// Accumulate, argmax and decision stage with the result output register.
// ----------------------------------------------------------------------------
module dtse_eval (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dtse_pkg::cfg_t                    cfg,
  input  logic                              s2_vld,
  input  dtse_pkg::eval_t                   s2,
  output logic                              advance,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dtse_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int EXT_W = dtse_pkg::ACC_W - dtse_pkg::PROD_W;
  localparam int WEXT_W = dtse_pkg::ACC_W - dtse_pkg::FEAT_W - dtse_pkg::WIDE_SHIFT;

  dtse_pkg::acc_t              acc_r;
  dtse_pkg::acc_t              acc_nxt;
  dtse_pkg::feat_t             best_val_r;
  dtse_pkg::feat_t             best_val_nxt;
  logic [dtse_pkg::SLOT_W-1:0] best_slot_r;
  logic [dtse_pkg::SLOT_W-1:0] best_slot_nxt;
  logic                        out_vld_r;
  logic                        out_right_r;
  dtse_pkg::acc_t              out_resp_r;

  dtse_pkg::acc_t              prod_ext;
  dtse_pkg::acc_t              acc_base;
  dtse_pkg::acc_t              wide;
  dtse_pkg::acc_t              sat_sum;
  logic [dtse_pkg::ACC_W:0]    sum;
  dtse_pkg::acc_t              resp;
  logic                        right;
  logic                        step;

  assign advance = !(s2_vld && s2.last && out_vld_r && !out_tready);
  assign step    = s2_vld && advance;

  always_comb begin
    prod_ext = {{EXT_W{s2.prod[dtse_pkg::PROD_W-1]}}, s2.prod};
    acc_base = s2.first ? cfg.bias : acc_r;
    sum      = {acc_base[dtse_pkg::ACC_W-1], acc_base} +
               {prod_ext[dtse_pkg::ACC_W-1], prod_ext};
    if (sum[dtse_pkg::ACC_W] != sum[dtse_pkg::ACC_W-1]) begin
      sat_sum = sum[dtse_pkg::ACC_W] ? dtse_pkg::ACC_MIN : dtse_pkg::ACC_MAX;
    end else begin
      sat_sum = sum[dtse_pkg::ACC_W-1:0];
    end
    wide = {{WEXT_W{s2.feat[dtse_pkg::FEAT_W-1]}}, s2.feat,
            {dtse_pkg::WIDE_SHIFT{1'b0}}};

    if (s2.oblique) begin
      acc_nxt = sat_sum;
    end else if (s2.first) begin
      acc_nxt = wide;
    end else begin
      acc_nxt = acc_r;
    end

    if (s2.first) begin
      best_val_nxt  = s2.feat;
      best_slot_nxt = '0;
    end else if ($signed(s2.feat) > $signed(best_val_r)) begin
      best_val_nxt  = s2.feat;
      best_slot_nxt = s2.slot;
    end else begin
      best_val_nxt  = best_val_r;
      best_slot_nxt = best_slot_r;
    end

    if (s2.ordinal) begin
      resp  = dtse_pkg::ACC_W'(best_slot_nxt);
      right = (best_slot_nxt != cfg.ordinal_target);
    end else begin
      resp  = acc_nxt;
      right = !($signed(acc_nxt) < $signed(cfg.threshold));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      best_val_r  <= '0;
      best_slot_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (step) begin
        acc_r       <= acc_nxt;
        best_val_r  <= best_val_nxt;
        best_slot_r <= best_slot_nxt;
      end
      if (step && s2.last) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && s2.last) begin
      out_right_r <= right;
      out_resp_r  <= resp;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(dtse_pkg::OUT_TDATA_W-dtse_pkg::ACC_W-1){1'b0}},
                       out_resp_r, out_right_r};

endmodule

// ===== hdl/decision_tree_split_eval.sv =====
// ----------------------------------------------------------------------------
// decision_tree_split_eval
// Random-forest split node evaluator: threshold, oblique and ordinal splits.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock cycle, weight loads and features
// alike. A result beat comes from the feature beat at the last slot through
// the weight RAM read register, the feature-by-weight multiply register, and
// the output register, which takes the saturating accumulate and threshold
// compare. The input stalls only while a finished result waits in the output
// register and the next result is already due behind it. The weight table
// needs no clearing pass after reset: reset clears each entry's valid bit.
module decision_tree_split_eval #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: slot [2:0], value [18:3], zero padding [23:19].
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dtse_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: opcode [0].
  input  logic                               in_tuser,
  // out_tdata: goes_right [0], response [40:1], zero padding [47:41].
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dtse_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [dtse_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [dtse_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [dtse_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int KMAX = (MAX_SLOTS < dtse_pkg::HW_SLOTS) ? MAX_SLOTS : dtse_pkg::HW_SLOTS;

  dtse_pkg::cfg_t              cfg;
  logic                        advance;
  logic                        accept;
  logic [dtse_pkg::SLOT_W-1:0] in_slot;
  dtse_pkg::feat_t             in_value;
  logic [dtse_pkg::CNT_W-1:0]  k_eff;
  logic [dtse_pkg::CNT_W-1:0]  slot_ext;
  logic                        feat_ok;
  logic                        load_we;
  logic [AW-1:0]               addr;
  logic [dtse_pkg::WGT_W-1:0]  rdata;
  dtse_pkg::wgt_t              wgt;

  logic [MAX_SLOTS-1:0]        wvld_r;
  logic                        s1_vld_r;
  logic                        s1_first_r;
  logic                        s1_last_r;
  logic                        s1_oblique_r;
  logic                        s1_ordinal_r;
  logic [dtse_pkg::SLOT_W-1:0] s1_slot_r;
  dtse_pkg::feat_t             s1_feat_r;
  logic                        s1_wvld_r;
  logic                        s2_vld_r;
  dtse_pkg::eval_t             s2_r;

  assign cfg_pready = 1'b1;
  assign in_tready  = advance;
  assign accept     = in_tvalid && advance;
  assign in_slot    = in_tdata[dtse_pkg::SLOT_W-1:0];
  assign in_value   = in_tdata[dtse_pkg::SLOT_W +: dtse_pkg::FEAT_W];
  assign slot_ext   = dtse_pkg::CNT_W'(in_slot);
  assign addr       = AW'(in_slot);

  always_comb begin
    if (cfg.slot_count == '0) begin
      k_eff = dtse_pkg::CNT_W'(1);
    end else if (cfg.slot_count > dtse_pkg::CNT_W'(KMAX)) begin
      k_eff = dtse_pkg::CNT_W'(KMAX);
    end else begin
      k_eff = cfg.slot_count;
    end
  end

  assign feat_ok = accept && (in_tuser == dtse_pkg::OP_FEATURE) && (slot_ext < k_eff);
  assign load_we = accept && (in_tuser == dtse_pkg::OP_LOAD) &&
                   (32'(in_slot) < MAX_SLOTS);

  dtse_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  dtse_ram #(
    .WIDTH (dtse_pkg::WGT_W),
    .DEPTH (MAX_SLOTS)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (addr),
    .wdata (in_value),
    .re    (advance),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r   <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (load_we) begin
        wvld_r[addr] <= 1'b1;
      end
      if (advance) begin
        s1_vld_r <= feat_ok;
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  assign wgt = s1_wvld_r ? $signed(rdata) : '0;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_first_r   <= (in_slot == '0);
      s1_last_r    <= (slot_ext == k_eff - dtse_pkg::CNT_W'(1));
      s1_oblique_r <= (cfg.split_mode == dtse_pkg::MODE_OBLIQUE);
      s1_ordinal_r <= (cfg.split_mode == dtse_pkg::MODE_ORDINAL);
      s1_slot_r    <= in_slot;
      s1_feat_r    <= in_value;
      s1_wvld_r    <= wvld_r[addr];
      s2_r.first   <= s1_first_r;
      s2_r.last    <= s1_last_r;
      s2_r.oblique <= s1_oblique_r;
      s2_r.ordinal <= s1_ordinal_r;
      s2_r.slot    <= s1_slot_r;
      s2_r.feat    <= s1_feat_r;
      s2_r.prod    <= dtse_pkg::prod_t'(s1_feat_r) * dtse_pkg::prod_t'(wgt);
    end
  end

  dtse_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s2_vld     (s2_vld_r),
    .s2         (s2_r),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hdl/dtse_checker.sv =====
// ----------------------------------------------------------------------------
// dtse_checker
// Port-level checks of the split evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtse_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dtse_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic in_acc;
  logic load_acc;

  assign in_acc   = in_tvalid && in_tready;
  assign load_acc = in_acc && (in_tuser == dtse_pkg::OP_LOAD);

  `ASSERT_NEXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_NEXT(a_reset_idle, clk, 1'b0, !rst_n, !out_tvalid)
  `ASSERT_IMPLIES(a_result_source, clk, !rst_n, $rose(out_tvalid), $past(in_acc, 3))
  `ASSERT_NEXT(a_load_silent, clk, !rst_n, load_acc ##2 1'b1, !$rose(out_tvalid))

endmodule

bind decision_tree_split_eval dtse_checker u_dtse_checker (.*);

// ===== sim/decision_tree_split_eval_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decision_tree_split_eval_test
// Self-checking bench for the split node evaluator. A short directed part
// covers threshold, oblique and ordinal splits, saturation, slot count limits,
// out-of-order and ignored slots and a mode change in the middle of a sample.
// Random phases then stream well-formed samples mixed with stray beats under
// random configurations, with random gaps on both stream interfaces. Every
// result beat is checked against an internal copy of the split arithmetic.
// ----------------------------------------------------------------------------
module decision_tree_split_eval_test;

  localparam logic [dtse_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam dtse_pkg::feat_t FEAT_MAX = 16'sh7FFF;
  localparam dtse_pkg::feat_t FEAT_MIN = 16'sh8000;

  typedef struct {
    logic           goes_right;
    dtse_pkg::acc_t response;
  } split_result_t;

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [dtse_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [dtse_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_psel = 1'b0;
  logic                             cfg_penable = 1'b0;
  logic                             cfg_pwrite = 1'b0;
  logic [dtse_pkg::CFG_AW-1:0]      cfg_paddr = '0;
  logic [dtse_pkg::CFG_DW-1:0]      cfg_pwdata = '0;
  logic [dtse_pkg::CFG_DW-1:0]      cfg_prdata;
  logic                             cfg_pready;

  // Shadow configuration and split state.
  logic [dtse_pkg::MODE_W-1:0] cfg_mode = dtse_pkg::MODE_THRESHOLD;
  logic [dtse_pkg::CNT_W-1:0]  cfg_count = 4'd1;
  dtse_pkg::acc_t              cfg_thr = '0;
  dtse_pkg::acc_t              cfg_bias = '0;
  logic [dtse_pkg::SLOT_W-1:0] cfg_target = '0;
  dtse_pkg::wgt_t              weight_mem [dtse_pkg::HW_SLOTS];
  dtse_pkg::acc_t              running_sum = '0;
  dtse_pkg::feat_t             best_feat = '0;
  logic [dtse_pkg::SLOT_W-1:0] best_pos = '0;

  split_result_t splits_due [$];
  int            mismatch_count = 0;
  int            idle_pct = 11;

  decision_tree_split_eval DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    foreach (weight_mem[i]) weight_mem[i] = '0;
  end

  function automatic int slot_limit();
    if (cfg_count == 0) return 1;
    if (cfg_count > dtse_pkg::HW_SLOTS) return dtse_pkg::HW_SLOTS;
    return int'(cfg_count);
  endfunction

  function automatic dtse_pkg::acc_t clamp_acc(longint v);
    if (v > longint'(dtse_pkg::ACC_MAX)) return dtse_pkg::ACC_MAX;
    if (v < longint'(dtse_pkg::ACC_MIN)) return dtse_pkg::ACC_MIN;
    return dtse_pkg::acc_t'(v);
  endfunction

  // Updates the split state for one accepted beat and queues the result
  // when the beat closes a sample.
  function automatic void eval_split_beat(logic op, logic [dtse_pkg::SLOT_W-1:0] slot,
                                          dtse_pkg::feat_t value);
    int            k;
    longint        prod;
    split_result_t res;
    if (op == dtse_pkg::OP_LOAD) begin
      weight_mem[slot] = value;
      return;
    end
    k = slot_limit();
    if (slot >= k) return;
    prod = longint'(value) * longint'(weight_mem[slot]);
    if (slot == 0) begin
      if (cfg_mode == dtse_pkg::MODE_OBLIQUE) begin
        running_sum = clamp_acc(longint'(cfg_bias) + prod);
      end else begin
        running_sum = clamp_acc(longint'(value) * 32768);
      end
      best_feat = value;
      best_pos = '0;
    end else begin
      if (cfg_mode == dtse_pkg::MODE_OBLIQUE) begin
        running_sum = clamp_acc(longint'(running_sum) + prod);
      end
      if (value > best_feat) begin
        best_feat = value;
        best_pos = slot;
      end
    end
    if (slot != k - 1) return;
    if (cfg_mode == dtse_pkg::MODE_ORDINAL) begin
      res.response = dtse_pkg::acc_t'({1'b0, best_pos});
      res.goes_right = (best_pos != cfg_target);
    end else begin
      res.response = running_sum;
      res.goes_right = !(running_sum < cfg_thr);
    end
    splits_due.push_back(res);
  endfunction

  task automatic send_beat(logic op, logic [dtse_pkg::SLOT_W-1:0] slot,
                           dtse_pkg::feat_t value);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {{(dtse_pkg::IN_TDATA_W - dtse_pkg::FEAT_W - dtse_pkg::SLOT_W){1'b0}},
                 value, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    eval_split_beat(op, slot, value);
  endtask

  task automatic write_reg(dtse_pkg::reg_idx_t idx, logic [dtse_pkg::CFG_DW-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      dtse_pkg::REG_SPLIT_MODE: cfg_mode = data[dtse_pkg::MODE_W-1:0];
      dtse_pkg::REG_SLOT_COUNT: cfg_count = data[dtse_pkg::CNT_W-1:0];
      dtse_pkg::REG_THRESHOLD:  cfg_thr = data[dtse_pkg::ACC_W-1:0];
      dtse_pkg::REG_BIAS:       cfg_bias = data[dtse_pkg::ACC_W-1:0];
      dtse_pkg::REG_ORD_TARGET: cfg_target = data[dtse_pkg::SLOT_W-1:0];
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the input until every queued result has left, then lets the
  // pipeline run empty so that trailing feature beats have settled.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (splits_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic dtse_pkg::feat_t rand_value();
    case ($urandom_range(15))
      0: return FEAT_MAX;
      1: return FEAT_MIN;
      2: return '0;
      3: return dtse_pkg::feat_t'($urandom_range(3));
      default: return dtse_pkg::feat_t'($urandom);
    endcase
  endfunction

  function automatic dtse_pkg::acc_t rand_acc();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return dtse_pkg::ACC_MAX;
      1: return dtse_pkg::ACC_MIN;
      2, 3: return dtse_pkg::acc_t'({$urandom, $urandom});
      default: return dtse_pkg::acc_t'($signed(r));
    endcase
  endfunction

  function automatic logic [dtse_pkg::MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(9);
    if (r < 3) return dtse_pkg::MODE_THRESHOLD;
    if (r < 6) return dtse_pkg::MODE_OBLIQUE;
    if (r < 9) return dtse_pkg::MODE_ORDINAL;
    return MODE_UNUSED;
  endfunction

  function automatic logic [dtse_pkg::CNT_W-1:0] pick_count();
    if ($urandom_range(7) == 0) return dtse_pkg::CNT_W'($urandom_range(15));
    return dtse_pkg::CNT_W'($urandom_range(1, dtse_pkg::HW_SLOTS));
  endfunction

  task automatic test_reset_defaults();
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, FEAT_MAX);
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, FEAT_MIN);
  endtask

  task automatic test_threshold_extremes();
    settle_block();
    write_reg(dtse_pkg::REG_THRESHOLD, dtse_pkg::CFG_DW'(dtse_pkg::ACC_MAX));
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, '0);
    settle_block();
    write_reg(dtse_pkg::REG_THRESHOLD, dtse_pkg::CFG_DW'(dtse_pkg::ACC_MIN));
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, FEAT_MIN);
  endtask

  task automatic test_mode_three();
    settle_block();
    write_reg(dtse_pkg::REG_SPLIT_MODE, dtse_pkg::CFG_DW'(MODE_UNUSED));
    write_reg(dtse_pkg::REG_THRESHOLD, '0);
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, -16'sd1);
  endtask

  task automatic test_slot_count_limits();
    settle_block();
    write_reg(dtse_pkg::REG_SPLIT_MODE, dtse_pkg::CFG_DW'(dtse_pkg::MODE_THRESHOLD));
    write_reg(dtse_pkg::REG_SLOT_COUNT, '0);
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, 16'sd7);
    send_beat(dtse_pkg::OP_FEATURE, 3'd1, 16'sd9);
  endtask

  task automatic test_oblique_saturation();
    settle_block();
    write_reg(dtse_pkg::REG_SPLIT_MODE, dtse_pkg::CFG_DW'(dtse_pkg::MODE_OBLIQUE));
    write_reg(dtse_pkg::REG_SLOT_COUNT, dtse_pkg::CFG_DW'(2));
    write_reg(dtse_pkg::REG_BIAS, dtse_pkg::CFG_DW'(dtse_pkg::ACC_MAX));
    write_reg(dtse_pkg::REG_THRESHOLD, dtse_pkg::CFG_DW'(dtse_pkg::ACC_MAX));
    send_beat(dtse_pkg::OP_LOAD, 3'd0, FEAT_MAX);
    send_beat(dtse_pkg::OP_LOAD, 3'd1, FEAT_MIN);
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, FEAT_MAX);
    send_beat(dtse_pkg::OP_FEATURE, 3'd1, FEAT_MAX);
    settle_block();
    write_reg(dtse_pkg::REG_BIAS, dtse_pkg::CFG_DW'(dtse_pkg::ACC_MIN));
    write_reg(dtse_pkg::REG_THRESHOLD, dtse_pkg::CFG_DW'(dtse_pkg::ACC_MIN));
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, FEAT_MIN);
    send_beat(dtse_pkg::OP_FEATURE, 3'd1, FEAT_MIN);
  endtask

  task automatic test_slot_order();
    settle_block();
    write_reg(dtse_pkg::REG_SLOT_COUNT, dtse_pkg::CFG_DW'(15));
    write_reg(dtse_pkg::REG_BIAS, '0);
    write_reg(dtse_pkg::REG_THRESHOLD, '0);
    send_beat(dtse_pkg::OP_FEATURE, 3'd3, 16'sd100);
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, -16'sd5);
    send_beat(dtse_pkg::OP_FEATURE, 3'd7, 16'sd256);
    settle_block();
    write_reg(dtse_pkg::REG_SLOT_COUNT, dtse_pkg::CFG_DW'(4));
    send_beat(dtse_pkg::OP_FEATURE, 3'd6, FEAT_MAX);
    send_beat(dtse_pkg::OP_FEATURE, 3'd3, -16'sd300);
  endtask

  task automatic test_ordinal_argmax();
    settle_block();
    write_reg(dtse_pkg::REG_SPLIT_MODE, dtse_pkg::CFG_DW'(dtse_pkg::MODE_ORDINAL));
    write_reg(dtse_pkg::REG_SLOT_COUNT, dtse_pkg::CFG_DW'(3));
    write_reg(dtse_pkg::REG_ORD_TARGET, '0);
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, 16'sd5);
    send_beat(dtse_pkg::OP_FEATURE, 3'd1, 16'sd5);
    send_beat(dtse_pkg::OP_FEATURE, 3'd2, 16'sd3);
    settle_block();
    write_reg(dtse_pkg::REG_ORD_TARGET, dtse_pkg::CFG_DW'(1));
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, 16'sd1);
    send_beat(dtse_pkg::OP_FEATURE, 3'd1, 16'sd9);
    send_beat(dtse_pkg::OP_FEATURE, 3'd2, 16'sd9);
  endtask

  task automatic test_mode_switch_mid_sample();
    settle_block();
    write_reg(dtse_pkg::REG_SPLIT_MODE, dtse_pkg::CFG_DW'(dtse_pkg::MODE_OBLIQUE));
    write_reg(dtse_pkg::REG_SLOT_COUNT, dtse_pkg::CFG_DW'(2));
    send_beat(dtse_pkg::OP_FEATURE, 3'd0, 16'sd1000);
    settle_block();
    write_reg(dtse_pkg::REG_SPLIT_MODE, dtse_pkg::CFG_DW'(dtse_pkg::MODE_ORDINAL));
    send_beat(dtse_pkg::OP_FEATURE, 3'd1, -16'sd1);
  endtask

  task automatic test_random_samples();
    int   beats;
    int   phase_beats;
    int   phase;
    int   k;
    int   s;
    logic op;
    logic [dtse_pkg::SLOT_W-1:0] sl;
    beats = 0;
    phase = 0;
    while (beats < 400) begin
      settle_block();
      idle_pct = (phase == 2) ? 0 : 11;
      write_reg(dtse_pkg::REG_SPLIT_MODE, dtse_pkg::CFG_DW'(pick_mode()));
      write_reg(dtse_pkg::REG_SLOT_COUNT, dtse_pkg::CFG_DW'(pick_count()));
      write_reg(dtse_pkg::REG_THRESHOLD, dtse_pkg::CFG_DW'(rand_acc()));
      write_reg(dtse_pkg::REG_BIAS, dtse_pkg::CFG_DW'(rand_acc()));
      write_reg(dtse_pkg::REG_ORD_TARGET, dtse_pkg::CFG_DW'($urandom_range(7)));
      k = slot_limit();
      phase_beats = 0;
      if ($urandom_range(1)) begin
        for (s = 0; s < dtse_pkg::HW_SLOTS; s++) begin
          send_beat(dtse_pkg::OP_LOAD, dtse_pkg::SLOT_W'(s), rand_value());
        end
        phase_beats += dtse_pkg::HW_SLOTS;
      end
      while (phase_beats < 40) begin
        if ($urandom_range(9) == 0) begin
          op = 1'($urandom_range(1));
          sl = dtse_pkg::SLOT_W'($urandom_range(7));
          send_beat(op, sl, rand_value());
          if (op == dtse_pkg::OP_LOAD || sl < k) phase_beats++;
        end else begin
          for (s = 0; s < k; s++) begin
            if ($urandom_range(19) == 0) begin
              send_beat(dtse_pkg::OP_LOAD, dtse_pkg::SLOT_W'($urandom_range(7)),
                        rand_value());
              phase_beats++;
            end
            if ($urandom_range(29) != 0) begin
              send_beat(dtse_pkg::OP_FEATURE, dtse_pkg::SLOT_W'(s), rand_value());
              phase_beats++;
            end
          end
        end
      end
      beats += phase_beats;
      phase++;
    end
    idle_pct = 11;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin : check_results
    split_result_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (splits_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected result beat: goes_right %0b response %0d",
                   out_tdata[0], $signed(out_tdata[dtse_pkg::ACC_W:1]));
        end
      end else begin
        due = splits_due.pop_front();
        if (out_tdata[0] !== due.goes_right ||
            $signed(out_tdata[dtse_pkg::ACC_W:1]) !== due.response) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Result mismatch: goes_right exp %0b got %0b, response exp %0d got %0d",
                     due.goes_right, out_tdata[0], due.response,
                     $signed(out_tdata[dtse_pkg::ACC_W:1]));
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_threshold_extremes();
    test_mode_three();
    test_slot_count_limits();
    test_oblique_saturation();
    test_slot_order();
    test_ordinal_argmax();
    test_mode_switch_mid_sample();
    test_random_samples();
    settle_block();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dtse_pkg.sv
hdl/dtse_ram.sv
hdl/dtse_cfg_regs.sv
hdl/dtse_eval.sv
hdl/decision_tree_split_eval.sv
hdl/dtse_checker.sv
sim/decision_tree_split_eval_test.sv
